// ----- src/lts_pkg.sv -----
// lts_pkg: shared types, codes and constants for the least loaded target selector.
// No dependencies; used by the top level, controller and datapath of the block and by its checker.
`default_nettype none

package lts_pkg;

    // Field widths
    localparam int ID_W    = 16;
    localparam int CNT_W   = 16;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = ID_W + CNT_W;

    // Default table depth
    localparam int MAX_TARGETS_DEF = 16;

    // Function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_CHOOSE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_TARGET = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

    // Input word
    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  service_id;
        logic [CNT_W-1:0] session_count;
    } item_t;

    // Result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   chosen_id;
        logic [CNT_W-1:0]  chosen_count;
    } result_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the input word, restart the scan
        logic issue;   // read the slot under the scan pointer
        logic commit;  // write back and present the result
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;  // scan pointer is on the last slot
    } stat_t;

endpackage

`default_nettype wire

// ----- src/least_loaded_target_selector.sv -----
// least_loaded_target_selector: top level, joins controller and datapath.
// Depends on lts_pkg, lts_ctrl, lts_dp (and lts_ram below it).
//
// Usage:
//   Input channel: a word (item) is taken at a rising edge where start is high
//   and busy is low. func 0 updates or inserts a target's session count,
//   func 1 picks the target with the smallest count (smallest id on a tie)
//   and bumps its count, saturating at the maximum.
//   Result channel: one word per input word on result, marked by done for a
//   single cycle. The receiver cannot stall; the word must be taken then.
//   Timing: every word scans the whole table through the registered read
//   port of the slot memory, one slot per cycle. busy stays high through
//   the scan, drain and commit states after acceptance; done shows in the
//   cycle after commit, when busy is low again, and a new word may be
//   started in that same cycle. No new word is taken before the last is done.
//   Reset: rst_n clears all slot valid bits, so the table starts empty; the
//   slot memory itself is not cleared and needs no clearing pass.
`default_nettype none

module least_loaded_target_selector #(
    parameter int MAX_TARGETS = lts_pkg::MAX_TARGETS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  lts_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output lts_pkg::result_t result
);

    lts_pkg::ctrl_t ctrl;
    lts_pkg::stat_t stat;

    lts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    lts_dp #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

// ----- src/lts_ram.sv -----
// lts_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module lts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/lts_ctrl.sv -----
// lts_ctrl: controller state machine of the selector (idle, scan, drain, commit).
// Depends on lts_pkg.
`default_nettype none

module lts_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  lts_pkg::stat_t stat,
    output lts_pkg::ctrl_t ctrl,
    output logic           busy
);

    lts_pkg::state_t state_reg;
    lts_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lts_pkg::ST_SCAN;
                end
            end
            lts_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = lts_pkg::ST_DRAIN;
                end
            end
            lts_pkg::ST_DRAIN:
            begin
                state_next = lts_pkg::ST_COMMIT;
            end
            lts_pkg::ST_COMMIT:
            begin
                state_next = lts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        case (state_reg)
            lts_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            lts_pkg::ST_SCAN:
            begin
                ctrl.issue = 1'b1;
            end
            lts_pkg::ST_DRAIN:
            begin
                ctrl = '0;
            end
            lts_pkg::ST_COMMIT:
            begin
                ctrl.commit = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/lts_dp.sv -----
// lts_dp: datapath of the selector: slot table, scan pointer, match and minimum
// trackers, write-back and result register. Depends on lts_pkg and lts_ram.
`default_nettype none

module lts_dp #(
    parameter int MAX_TARGETS = lts_pkg::MAX_TARGETS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  lts_pkg::item_t   item,
    input  lts_pkg::ctrl_t   ctrl,
    output lts_pkg::stat_t   stat,
    output logic             done,
    output lts_pkg::result_t result
);

    localparam int IDX_W = $clog2(MAX_TARGETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TARGETS - 1);

    // Latched input word
    lts_pkg::item_t item_reg;

    // Scan pointer and read pipeline
    logic [IDX_W-1:0] idx_reg;
    logic             rd_pend_reg;
    logic             valid_q_reg;
    logic [IDX_W-1:0] slot_q_reg;

    // Slot valid bits
    logic [MAX_TARGETS-1:0] valid_reg;
    logic [MAX_TARGETS-1:0] valid_next;

    // Update trackers
    logic             match_reg,     match_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic             free_reg,      free_next;
    logic [IDX_W-1:0] free_slot_reg,  free_slot_next;

    // Choose trackers
    logic                      best_reg,      best_next;
    logic [IDX_W-1:0]          best_slot_reg, best_slot_next;
    logic [lts_pkg::ID_W-1:0]  best_id_reg,   best_id_next;
    logic [lts_pkg::CNT_W-1:0] best_cnt_reg,  best_cnt_next;

    // Result register
    logic             done_reg, done_next;
    lts_pkg::result_t result_reg, result_next;

    // Table memory
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [lts_pkg::ENTRY_W-1:0] ram_wdata;
    logic [lts_pkg::ENTRY_W-1:0] ram_rdata;
    logic [lts_pkg::ID_W-1:0]    rd_id;
    logic [lts_pkg::CNT_W-1:0]   rd_cnt;
    logic [lts_pkg::CNT_W-1:0]   inc_cnt;

    lts_ram #(
        .WIDTH (lts_pkg::ENTRY_W),
        .DEPTH (MAX_TARGETS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_id  = ram_rdata[lts_pkg::ENTRY_W-1:lts_pkg::CNT_W];
    assign rd_cnt = ram_rdata[lts_pkg::CNT_W-1:0];

    // Saturating increment of the chosen count
    assign inc_cnt = (best_cnt_reg == '1) ? best_cnt_reg
                                          : lts_pkg::CNT_W'(best_cnt_reg + 1'b1);

    assign stat.scan_last = (idx_reg == LAST_IDX);

    // Trackers, write-back and result
    always_comb
    begin
        match_next      = match_reg;
        match_slot_next = match_slot_reg;
        free_next       = free_reg;
        free_slot_next  = free_slot_reg;
        best_next       = best_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        best_cnt_next   = best_cnt_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        result_next     = '0;
        ram_we          = 1'b0;
        ram_waddr       = match_slot_reg;
        ram_wdata       = {item_reg.service_id, item_reg.session_count};

        if (ctrl.load)
        begin
            match_next = 1'b0;
            free_next  = 1'b0;
            best_next  = 1'b0;
        end

        // Look at the word read in the previous cycle
        if (rd_pend_reg)
        begin
            if (valid_q_reg)
            begin
                if (rd_id == item_reg.service_id)
                begin
                    match_next      = 1'b1;
                    match_slot_next = slot_q_reg;
                end
                if (!best_reg || (rd_cnt < best_cnt_reg) ||
                    ((rd_cnt == best_cnt_reg) && (rd_id < best_id_reg)))
                begin
                    best_next      = 1'b1;
                    best_slot_next = slot_q_reg;
                    best_id_next   = rd_id;
                    best_cnt_next  = rd_cnt;
                end
            end
            else if (!free_reg)
            begin
                free_next      = 1'b1;
                free_slot_next = slot_q_reg;
            end
        end

        if (ctrl.commit)
        begin
            done_next          = 1'b1;
            result_next.status = lts_pkg::STATUS_OK;
            if (item_reg.func == lts_pkg::FUNC_CHOOSE)
            begin
                if (best_reg)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = best_slot_reg;
                    ram_wdata                = {best_id_reg, inc_cnt};
                    result_next.chosen_id    = best_id_reg;
                    result_next.chosen_count = inc_cnt;
                end
                else
                begin
                    result_next.status = lts_pkg::STATUS_NO_TARGET;
                end
            end
            else if (item_reg.service_id != '0)
            begin
                if (match_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = match_slot_reg;
                end
                else if (free_reg)
                begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = free_slot_reg;
                    valid_next[free_slot_reg] = 1'b1;
                end
                else
                begin
                    result_next.status = lts_pkg::STATUS_FULL;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
            best_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ctrl.issue;
            valid_reg   <= valid_next;
            match_reg   <= match_next;
            free_reg    <= free_next;
            best_reg    <= best_next;
            done_reg    <= done_next;
            if (ctrl.load)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.issue)
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= item;
        end
        if (ctrl.issue)
        begin
            valid_q_reg <= valid_reg[idx_reg];
            slot_q_reg  <= idx_reg;
        end
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        best_slot_reg  <= best_slot_next;
        best_id_reg    <= best_id_next;
        best_cnt_reg   <= best_cnt_next;
        result_reg     <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- src/lts_checker.sv -----
// lts_checker: port-level assertions for the selector, bound to the top level.
// Depends on lts_pkg and least_loaded_target_selector.
`default_nettype none

module lts_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              start,
    input wire              busy,
    input wire              done,
    input lts_pkg::result_t result
);

    // An accepted word makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // A result only appears once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == lts_pkg::STATUS_OK ||
                  result.status == lts_pkg::STATUS_NO_TARGET ||
                  result.status == lts_pkg::STATUS_FULL))
        else $error("undefined status code");

    // A failed word carries no id or count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != lts_pkg::STATUS_OK) |->
            (result.chosen_id == '0 && result.chosen_count == '0))
        else $error("failed word with nonzero payload");

    // A chosen target always has a count of at least one after the bump
    a_chosen_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.chosen_id != '0) |-> (result.chosen_count != '0))
        else $error("chosen target with zero count");

endmodule

bind least_loaded_target_selector lts_checker u_lts_checker (.*);

`default_nettype wire
